### rtl/core/sstf_pkg.sv
// Shared types and constants for the shortest-seek-first disk scheduler.
package sstf_pkg;

  localparam int unsigned SLICE_W   = 8;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRACK     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_TICKS = 4'd1;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  typedef enum logic [1:0] {
    EV_DONE      = 2'd0,
    EV_BAD_TRACK = 2'd1,
    EV_FULL      = 2'd2
  } event_e;

  // status of the seek unit for one entry against the head
  typedef struct packed {
    logic closer;    // distance below best so far
    logic above;     // entry track above head
    logic on_track;  // entry track equals head
  } seek_flags_t;

endpackage

### rtl/core/sstf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sstf_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sstf_seek_unit.sv
// Shared seek unit: head-to-track distance and compares.
module sstf_seek_unit #(
  parameter int unsigned TRACK_BITS = 16
) (
  input  logic [TRACK_BITS-1:0] head_i,
  input  logic [TRACK_BITS-1:0] track_i,
  input  logic [TRACK_BITS-1:0] best_dist_i,
  output logic [TRACK_BITS-1:0] dist_o,
  output sstf_pkg::seek_flags_t flags_o
);
  import sstf_pkg::*;

  logic above;

  assign above          = track_i > head_i;
  assign dist_o         = above ? (track_i - head_i) : (head_i - track_i);
  assign flags_o.above    = above;
  assign flags_o.on_track = (track_i == head_i);
  assign flags_o.closer   = dist_o < best_dist_i;

endmodule

### rtl/core/sstf_disk_scheduler.sv
// Top level of the shortest-seek-first disk scheduler with a simulated head.
// The block takes one beat at a time on the slave stream: tuser[0] = 0 is a
// tick, 1 is a request with id and track in tdata. A request is checked
// against max_track (bad track wins over full queue) and written to the
// queue RAM as it is accepted. A tick scans all queued entries through one shared
// seek unit, one entry per cycle out of the queue RAM, swaps the nearest
// entry (first strictly smaller distance) into slot 0, then either counts
// its slice down, steps the head one track toward it, or retires it and
// compacts the queue by a read/write sweep. A rejection or a retirement
// takes longer while an earlier result still waits in the output
// register. The scan, the swap and the sweep are shaped by the single read
// and single write port of the queue RAM. The block is not ready while it
// works on a beat. Results go through an output register, so a new beat
// is taken while a result still waits on the master stream.
// There is no clearing pass: queue entries are only read below the count.
module sstf_disk_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TRACK_BITS  = 16,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // slave stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: requester_id, track, zero pad
  input  logic [((ID_BITS+TRACK_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: command
  input  logic [0:0]                             s_axis_tuser,
  // master stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tdata: requester_id_res, head_track, zero pad
  output logic [((ID_BITS+TRACK_BITS+7)/8)*8-1:0] m_axis_tdata,
  // tuser: event_res
  output logic [1:0]                             m_axis_tuser,
  // configuration writes
  input  logic                                   cfg_we_i,
  input  logic [sstf_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [sstf_pkg::CFG_W-1:0]             cfg_wdata_i
);
  import sstf_pkg::*;

  localparam int unsigned DATA_W = ((ID_BITS + TRACK_BITS + 7) / 8) * 8;
  localparam int unsigned IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned WORD_W = ID_BITS + TRACK_BITS + SLICE_W;
  localparam int unsigned TRK_LSB = SLICE_W;
  localparam int unsigned ID_LSB  = SLICE_W + TRACK_BITS;
  localparam int unsigned CMP_W  = (TRACK_BITS > CFG_W) ? TRACK_BITS : CFG_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_SWAP0 = 7'b0000100,
    S_SWAP1 = 7'b0001000,
    S_SERVE = 7'b0010000,
    S_SHIFT = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]      count_q, count_d;
  logic [TRACK_BITS-1:0] head_q, head_d;
  logic [CFG_W-1:0]      max_track_q;
  logic [SLICE_W-1:0]    service_q;

  // scan / shift sweep: shared index and one-deep read pipeline
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic                  pend_q, pend_d;
  logic [IDX_W-1:0]      pend_idx_q, pend_idx_d;

  logic [IDX_W-1:0]      best_idx_q, best_idx_d;
  logic [TRACK_BITS-1:0] best_dist_q, best_dist_d;
  logic [WORD_W-1:0]     best_word_q, best_word_d;
  logic [WORD_W-1:0]     first_word_q, first_word_d;

  event_e                res_event_q, res_event_d;
  logic [ID_BITS-1:0]    res_id_q, res_id_d;

  logic                  out_valid_q, out_valid_d;
  event_e                out_event_q, out_event_d;
  logic [ID_BITS-1:0]    out_id_q, out_id_d;
  logic [TRACK_BITS-1:0] out_head_q, out_head_d;

  // input beat fields
  logic                  in_cmd;
  logic [ID_BITS-1:0]    in_id;
  logic [TRACK_BITS-1:0] in_track;
  logic                  in_fire;
  logic                  bad_track;
  logic                  queue_full;

  assign in_cmd   = s_axis_tuser[0];
  assign in_id    = s_axis_tdata[ID_BITS-1:0];
  assign in_track = s_axis_tdata[ID_BITS +: TRACK_BITS];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign bad_track  = CMP_W'(in_track) > CMP_W'(max_track_q);
  assign queue_full = (count_q == CNT_W'(QUEUE_DEPTH));

  // queue RAM
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  sstf_ram #(
    .WIDTH(WORD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // shared seek unit: RAM output while scanning, slot 0 candidate when serving
  logic [TRACK_BITS-1:0] seek_track;
  logic [TRACK_BITS-1:0] seek_dist;
  seek_flags_t           seek_flags;

  assign seek_track = (state_q == S_SERVE) ? best_word_q[TRK_LSB +: TRACK_BITS]
                                           : ram_rdata[TRK_LSB +: TRACK_BITS];

  sstf_seek_unit #(
    .TRACK_BITS(TRACK_BITS)
  ) u_seek (
    .head_i     (head_q),
    .track_i    (seek_track),
    .best_dist_i(best_dist_q),
    .dist_o     (seek_dist),
    .flags_o    (seek_flags)
  );

  logic issue;
  assign issue = idx_q < count_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    head_d       = head_q;
    idx_d        = idx_q;
    pend_d       = 1'b0;
    pend_idx_d   = pend_idx_q;
    best_idx_d   = best_idx_q;
    best_dist_d  = best_dist_q;
    best_word_d  = best_word_q;
    first_word_d = first_word_q;
    res_event_d  = res_event_q;
    res_id_d     = res_id_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = best_word_q;
    ram_re       = 1'b0;
    ram_raddr    = idx_q[IDX_W-1:0];

    out_valid_d = out_valid_q && !m_axis_tready;
    out_event_d = out_event_q;
    out_id_d    = out_id_q;
    out_head_d  = out_head_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_cmd == CMD_REQUEST) begin
            if (bad_track || queue_full) begin
              res_event_d = bad_track ? EV_BAD_TRACK : EV_FULL;
              res_id_d    = in_id;
              state_d     = S_EMIT;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_q[IDX_W-1:0];
              ram_wdata = {in_id, in_track, service_q};
              count_d   = count_q + CNT_W'(1);
            end
          end else if (count_q != '0) begin
            idx_d   = '0;
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (issue) begin
          ram_re     = 1'b1;
          idx_d      = idx_q + CNT_W'(1);
          pend_d     = 1'b1;
          pend_idx_d = idx_q[IDX_W-1:0];
        end
        if (pend_q) begin
          if (pend_idx_q == '0) begin
            best_idx_d   = '0;
            best_dist_d  = seek_dist;
            best_word_d  = ram_rdata;
            first_word_d = ram_rdata;
          end else if (seek_flags.closer) begin
            best_idx_d  = pend_idx_q;
            best_dist_d = seek_dist;
            best_word_d = ram_rdata;
          end
        end
        if (!issue && !pend_q) begin
          state_d = (best_idx_q != '0) ? S_SWAP0 : S_SERVE;
        end
      end

      S_SWAP0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = best_word_q;
        state_d   = S_SWAP1;
      end

      S_SWAP1: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx_q;
        ram_wdata = first_word_q;
        state_d   = S_SERVE;
      end

      S_SERVE: begin
        if (seek_flags.on_track) begin
          if (best_word_q[SLICE_W-1:0] != '0) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = {best_word_q[WORD_W-1:SLICE_W],
                         best_word_q[SLICE_W-1:0] - SLICE_W'(1)};
            state_d   = S_IDLE;
          end else begin
            res_event_d = EV_DONE;
            res_id_d    = best_word_q[ID_LSB +: ID_BITS];
            idx_d       = CNT_W'(1);
            state_d     = S_SHIFT;
          end
        end else begin
          head_d  = seek_flags.above ? (head_q + TRACK_BITS'(1))
                                     : (head_q - TRACK_BITS'(1));
          state_d = S_IDLE;
        end
      end

      S_SHIFT: begin
        // read entry i, write it to i-1 when its read data comes back
        if (issue) begin
          ram_re     = 1'b1;
          idx_d      = idx_q + CNT_W'(1);
          pend_d     = 1'b1;
          pend_idx_d = idx_q[IDX_W-1:0];
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx_q - IDX_W'(1);
          ram_wdata = ram_rdata;
        end
        if (!issue && !pend_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_event_d = res_event_q;
          out_id_d    = res_id_q;
          out_head_d  = head_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      max_track_q <= CFG_W'(1023);
      service_q   <= SLICE_W'(10);
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_TRACK:     max_track_q <= cfg_wdata_i;
          CFG_SERVICE_TICKS: service_q   <= cfg_wdata_i[SLICE_W-1:0];
          default:           ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q   <= pend_idx_d;
    best_idx_q   <= best_idx_d;
    best_dist_q  <= best_dist_d;
    best_word_q  <= best_word_d;
    first_word_q <= first_word_d;
    res_event_q  <= res_event_d;
    res_id_q     <= res_id_d;
    out_event_q  <= out_event_d;
    out_id_q     <= out_id_d;
    out_head_q   <= out_head_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DATA_W'({out_head_q, out_id_q});
  assign m_axis_tuser  = out_event_q;

  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // count moves by at most one per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CNT_W'(1)) ||
      (count_q == $past(count_q) - CNT_W'(1)))
    else $error("queue count jumped");

  // head steps one track at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q != $past(head_q)) |->
      (head_q == $past(head_q) + TRACK_BITS'(1)) ||
      (head_q == $past(head_q) - TRACK_BITS'(1)))
    else $error("head moved more than one track");

  // a bad-track request goes straight to the result stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_cmd == CMD_REQUEST && bad_track) |=> (state_q == S_EMIT))
    else $error("bad-track request not rejected");

endmodule

### tb/sstf_tb_pkg.sv
// Scoreboard for the disk scheduler: queue and head tracking, expected results.
package sstf_tb_pkg;
  import sstf_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned TRK_W = 16;
  localparam int unsigned ID_W  = 16;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 4'd15;

  typedef struct packed {
    event_e           ev;
    logic [ID_W-1:0]  id;
    logic [TRK_W-1:0] head;
  } sched_event_t;

  class sched_checker;
    logic [TRK_W-1:0]   q_track [DEPTH];
    logic [ID_W-1:0]    q_id    [DEPTH];
    logic [SLICE_W-1:0] q_slice [DEPTH];
    int unsigned        q_count;
    logic [TRK_W-1:0]   head;
    logic [CFG_W-1:0]   limit_track;
    logic [SLICE_W-1:0] slice_load;
    sched_event_t       expected_events [$];
    int unsigned        fail_count;
    int unsigned        done_count;
    int unsigned        bad_count;
    int unsigned        full_count;

    function new();
      q_count     = 0;
      head        = '0;
      limit_track = 16'd1023;
      slice_load  = 8'd10;
      fail_count  = 0;
      done_count  = 0;
      bad_count   = 0;
      full_count  = 0;
    endfunction

    function int unsigned pending();
      return expected_events.size();
    endfunction

    function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_MAX_TRACK) begin
        limit_track = val;
      end else if (idx == CFG_SERVICE_TICKS) begin
        slice_load = val[SLICE_W-1:0];
      end
    endfunction

    function logic [TRK_W-1:0] seek_dist(logic [TRK_W-1:0] a, logic [TRK_W-1:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void post(event_e ev, logic [ID_W-1:0] id);
      sched_event_t e;
      e.ev   = ev;
      e.id   = id;
      e.head = head;
      expected_events.push_back(e);
      case (ev)
        EV_DONE:      done_count++;
        EV_BAD_TRACK: bad_count++;
        default:      full_count++;
      endcase
    endfunction

    // advance the scheduler by one accepted input beat
    function void note_beat(logic cmd, logic [ID_W-1:0] id, logic [TRK_W-1:0] trk);
      int unsigned        nearest;
      logic [TRK_W-1:0]   best_d;
      logic [TRK_W-1:0]   t_trk;
      logic [ID_W-1:0]    t_id;
      logic [SLICE_W-1:0] t_slice;
      if (cmd == CMD_REQUEST) begin
        if (trk > limit_track) begin
          post(EV_BAD_TRACK, id);
        end else if (q_count >= DEPTH) begin
          post(EV_FULL, id);
        end else begin
          q_track[q_count] = trk;
          q_id[q_count]    = id;
          q_slice[q_count] = slice_load;
          q_count++;
        end
        return;
      end
      if (q_count > 1) begin
        nearest = 0;
        best_d  = seek_dist(head, q_track[0]);
        for (int unsigned i = 1; i < q_count; i++) begin
          if (seek_dist(head, q_track[i]) < best_d) begin
            best_d  = seek_dist(head, q_track[i]);
            nearest = i;
          end
        end
        if (nearest != 0) begin
          t_trk   = q_track[0];
          t_id    = q_id[0];
          t_slice = q_slice[0];
          q_track[0] = q_track[nearest];
          q_id[0]    = q_id[nearest];
          q_slice[0] = q_slice[nearest];
          q_track[nearest] = t_trk;
          q_id[nearest]    = t_id;
          q_slice[nearest] = t_slice;
        end
      end
      if (q_count == 0) return;
      if (q_track[0] == head) begin
        if (q_slice[0] != 0) begin
          q_slice[0]--;
          return;
        end
        post(EV_DONE, q_id[0]);
        for (int unsigned i = 0; i + 1 < q_count; i++) begin
          q_track[i] = q_track[i+1];
          q_id[i]    = q_id[i+1];
          q_slice[i] = q_slice[i+1];
        end
        q_count--;
      end else if (q_track[0] > head) begin
        head++;
      end else begin
        head--;
      end
    endfunction

    // compare one accepted result beat with the oldest expectation
    function void check_beat(event_e ev, logic [ID_W-1:0] id, logic [TRK_W-1:0] hd);
      sched_event_t want;
      if (expected_events.size() == 0) begin
        $error("unexpected result beat: event_res %0d, requester_id_res %0d, head_track %0d",
               ev, id, hd);
        fail_count++;
        return;
      end
      want = expected_events.pop_front();
      if (ev !== want.ev) begin
        $error("event_res: expected %0d, got %0d", want.ev, ev);
        fail_count++;
      end
      if (id !== want.id) begin
        $error("requester_id_res: expected %0d, got %0d", want.id, id);
        fail_count++;
      end
      if (hd !== want.head) begin
        $error("head_track: expected %0d, got %0d", want.head, hd);
        fail_count++;
      end
    endfunction
  endclass

endpackage

### tb/tb_top.sv
// Self-checking bench for the shortest-seek-first disk scheduler.
module tb_top;
  import sstf_pkg::*;
  import sstf_tb_pkg::*;

  // a tick can scan and compact the whole queue
  localparam int unsigned SETTLE_CYCLES = 64;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata  = '0;
  logic [0:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_wdata_i   = '0;

  sched_checker sb = new();

  bit          tx_quiet   = 1'b0;  // sender runs without gaps while set
  bit          rx_quiet   = 1'b0;  // receiver runs without stalls while set
  int unsigned items_sent = 0;     // beats that can change state
  int unsigned n_requests = 0;
  int unsigned n_ticks    = 0;

  sstf_disk_scheduler #(
    .QUEUE_DEPTH (DEPTH),
    .TRACK_BITS  (TRK_W),
    .ID_BITS     (ID_W)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // requester_id, track
    .s_axis_tuser  (s_axis_tuser),   // command
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // requester_id_res, head_track
    .m_axis_tuser  (m_axis_tuser),   // event_res
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [ID_W-1:0] rand_id();
    return ID_W'($urandom_range(0, 65535));
  endfunction

  // Track near the head so that the head actually gets there; now and then
  // a wider reach, and optionally a track above the limit.
  function automatic logic [TRK_W-1:0] pick_track(input bit allow_bad);
    int lim;
    int span;
    int lo;
    int hi;
    lim = sb.limit_track;
    if (allow_bad && lim < 65535 && $urandom_range(0, 99) < 8) begin
      return TRK_W'($urandom_range(lim + 1, 65535));
    end
    span = ($urandom_range(0, 99) < 6) ? 64 : 6;
    lo   = int'(sb.head) - span;
    hi   = int'(sb.head) + span;
    if (lo < 0) lo = 0;
    if (hi > lim) hi = lim;
    if (lo > hi) lo = (hi > span) ? hi - span : 0;
    return TRK_W'($urandom_range(lo, hi));
  endfunction

  // One beat on the slave stream, after a random gap unless the sender is
  // in a quiet stretch. Valid stays high between back-to-back beats.
  task automatic send_beat(input logic cmd, input logic [ID_W-1:0] id,
                           input logic [TRK_W-1:0] trk);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 99) < 3) tx_quiet = !tx_quiet;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {trk, id};
    do @(posedge clk_i); while (!s_axis_tready);
    // a tick on an empty queue does nothing and is not counted
    if (cmd == CMD_REQUEST) begin
      n_requests++;
      items_sent++;
    end else if (sb.q_count != 0) begin
      n_ticks++;
      items_sent++;
    end
    sb.note_beat(cmd, id, trk);
  endtask

  // tdata is don't-care on a tick, so it carries noise
  task automatic send_tick();
    send_beat(CMD_TICK, rand_id(), TRK_W'($urandom_range(0, 65535)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.apply_config(idx, val);
    @(posedge clk_i);
  endtask

  // Hold the sender until every expected result is out, then give the block
  // time to finish a tick that produced none.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Fill the queue, overflow it twice, then a bad track while full if the
  // limit leaves a track above it (bad track must win over full queue).
  task automatic fill_queue();
    while (sb.q_count < DEPTH) send_beat(CMD_REQUEST, rand_id(), pick_track(1'b0));
    repeat (2) send_beat(CMD_REQUEST, rand_id(), pick_track(1'b0));
    if (sb.limit_track != 16'hFFFF) begin
      send_beat(CMD_REQUEST, rand_id(),
                TRK_W'($urandom_range(int'(sb.limit_track) + 1, 65535)));
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] lim, input logic [SLICE_W-1:0] svc,
                           input int unsigned n_items, input int unsigned req_pct,
                           input bit force_fill);
    int unsigned target;
    int unsigned pct;
    wait_drained();
    write_reg(CFG_MAX_TRACK, lim);
    write_reg(CFG_SERVICE_TICKS, CFG_W'(svc));
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_UNUSED_LO, CFG_W'($urandom_range(0, 65535)));
    end
    target = items_sent + n_items;
    if (force_fill) fill_queue();
    while (items_sent < target) begin
      // back off on requests while the queue is nearly full
      pct = (sb.q_count >= 12) ? req_pct / 3 : req_pct;
      if ($urandom_range(0, 99) < pct) begin
        if ($urandom_range(0, 99) < 4) begin
          fill_queue();
        end else begin
          send_beat(CMD_REQUEST, rand_id(), pick_track(1'b1));
        end
      end else begin
        send_tick();
      end
      if ($urandom_range(0, 99) < 2) wait_drained();
    end
  endtask

  // result side: random stall per beat, checks every accepted beat
  initial begin : result_sink
    int unsigned stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 99) < 3) rx_quiet = !rx_quiet;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      sb.check_beat(event_e'(m_axis_tuser), m_axis_tdata[ID_W-1:0],
                    m_axis_tdata[ID_W+TRK_W-1:ID_W]);
    end
  end

  initial begin : stimulus
    int unsigned rounds;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // slice register keeps only the low byte; unused index is ignored
    write_reg(CFG_SERVICE_TICKS, 16'hFF01);
    write_reg(CFG_UNUSED_HI, 16'hFFFF);

    // directed: empty tick, bad tracks just above the limit and at the top of the
    // field, a request on the head track, nearest-first reordering, and a distance tie
    send_tick();
    send_beat(CMD_REQUEST, 16'hFFFF, 16'd1024);
    send_beat(CMD_REQUEST, 16'h0000, 16'hFFFF);
    send_beat(CMD_REQUEST, 16'h1234, 16'd0);
    repeat (2) send_tick();              // slice down, then retire
    send_beat(CMD_REQUEST, 16'h00B0, 16'd3);
    send_beat(CMD_REQUEST, 16'h00C0, 16'd1);
    send_beat(CMD_REQUEST, 16'h00D0, 16'd1023);  // highest valid track
    repeat (7) send_tick();
    send_beat(CMD_REQUEST, 16'h00E0, 16'd1);     // head at 3: tracks 1 and 5
    send_beat(CMD_REQUEST, 16'h00F0, 16'd5);     // tie, lower slot wins
    repeat (4) send_tick();

    // random phases across the register extremes
    run_phase(16'd1023,  8'd0,   200, 35, 1'b1);
    run_phase(16'hFFFF,  8'd3,   200, 35, 1'b0);
    run_phase(16'd0,     8'd2,   100, 35, 1'b1);
    run_phase(16'd40000, 8'd1,   190, 35, 1'b0);
    run_phase(16'd300,   8'd255,  60,  4, 1'b0);
    rounds = 0;
    while (sb.done_count + sb.bad_count + sb.full_count < 48 && rounds < 10) begin
      run_phase(16'd1023, 8'd0, 50, 35, 1'b0);
      rounds++;
    end

    wait_drained();
    $display("Covered %0d requests and %0d working ticks over six register settings,",
             n_requests, n_ticks);
    $display("checking %0d completions, %0d bad-track and %0d full-queue rejections.",
             sb.done_count, sb.bad_count, sb.full_count);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
